/* rtl/tlbpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants of the tlb / page table translator
// address split, table sizes, counter width and the fill and lookup structs
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int VA_W        = 16;
  localparam int OFFSET_W    = 8;
  localparam int PAGE_W      = VA_W - OFFSET_W;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_W     = 8;
  localparam int NFF_W       = FRAME_W + 1;
  localparam int CNT_W       = 32;
  localparam int TLB_ENTRIES_DEFAULT = 16;

  // one new page to frame mapping, written into the tlb or the page table
  typedef struct packed {
    logic                en;
    logic [PAGE_W-1:0]   page;
    logic [FRAME_W-1:0]  frame;
  } map_fill_t;

  // result of the parallel tlb search
  typedef struct packed {
    logic                hit;
    logic [FRAME_W-1:0]  frame;
  } tlb_lookup_t;

endpackage
`default_nettype wire

/* rtl/tlbpt_tlb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_tlb: fully associative tlb
// parallel compare of all entries, lowest matching entry wins, fifo refill
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0]   look_page,
  input  wire tlbpt_pkg::map_fill_t           fill,
  output tlbpt_pkg::tlb_lookup_t              lookup
);

  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  logic [TLB_ENTRIES-1:0]          valid;
  logic [tlbpt_pkg::PAGE_W-1:0]    page_q  [TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0]   frame_q [TLB_ENTRIES];
  logic [IDX_W-1:0]                fifo_ptr;
  logic [IDX_W-1:0]                fifo_ptr_next;

  assign fifo_ptr_next = (fifo_ptr == IDX_W'(TLB_ENTRIES - 1)) ? '0 : fifo_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fifo_ptr <= '0;
    end else if (fill.en) begin
      valid[fifo_ptr] <= 1'b1;
      fifo_ptr        <= fifo_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      page_q[fifo_ptr]  <= fill.page;
      frame_q[fifo_ptr] <= fill.frame;
    end
  end

  // scan from the top so the lowest matching entry is the last to win
  always_comb begin
    lookup = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && page_q[i] == look_page) begin
        lookup.hit   = 1'b1;
        lookup.frame = frame_q[i];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/tlbpt_page_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_page_table: page table
// present bits in flops, frame numbers in a memory with a registered read
// ----------------------------------------------------------------------------
module tlbpt_page_table (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rd_en,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0]    rd_page,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0]    look_page,
  input  wire tlbpt_pkg::map_fill_t            fill,
  output logic                                 present,
  output logic [tlbpt_pkg::FRAME_W-1:0]        rd_frame
);

  logic [tlbpt_pkg::PAGE_COUNT-1:0] present_bits;
  logic [tlbpt_pkg::FRAME_W-1:0]    frame_mem [tlbpt_pkg::PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      present_bits <= '0;
    end else if (fill.en) begin
      present_bits[fill.page] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      frame_mem[fill.page] <= fill.frame;
    end
  end

  // write-through bypass: a fill in the same cycle is seen by the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (fill.en && fill.page == rd_page) begin
        rd_frame <= fill.frame;
      end else begin
        rd_frame <= frame_mem[rd_page];
      end
    end
  end

  assign present = present_bits[look_page];

endmodule
`default_nettype wire

/* rtl/tlb_page_table_translator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_page_table_translator: virtual to physical address translation
// tlb search, page table lookup on a miss, frame assignment on a page fault
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   req       req_valid/req_ready   virt_addr
//   rsp       rsp_valid/rsp_ready   phys_addr, tlb_hit, page_fault,
//                                   hits_so_far, faults_so_far, accesses_so_far
//
// one beat per cycle sustained while rsp_ready is high; a request beat is
// captured in the input register (page table read) and moves into the
// response register, which drives rsp_valid, once it is empty or draining;
// reset clears the tlb valid bits, page table present bits, the fifo pointer,
// the free frame counter and the statistics counters; no clearing pass
// with rsp_ready low, one more beat is taken into the input register before
// req_ready drops
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic [tlbpt_pkg::VA_W-1:0]       virt_addr,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic [tlbpt_pkg::VA_W-1:0]            phys_addr,
  output logic                                  tlb_hit,
  output logic                                  page_fault,
  output logic [tlbpt_pkg::CNT_W-1:0]           hits_so_far,
  output logic [tlbpt_pkg::CNT_W-1:0]           faults_so_far,
  output logic [tlbpt_pkg::CNT_W-1:0]           accesses_so_far
);

  // input register
  logic                                 s1_valid;
  logic [tlbpt_pkg::PAGE_W-1:0]         s1_page;
  logic [tlbpt_pkg::OFFSET_W-1:0]       s1_offset;
  logic                                 s1_adv;
  logic                                 req_fire;

  // lookup results for the beat in the input register
  tlbpt_pkg::tlb_lookup_t               tlb_res;
  logic                                 pt_present;
  logic [tlbpt_pkg::FRAME_W-1:0]        pt_frame;
  logic                                 fault;
  logic [tlbpt_pkg::FRAME_W-1:0]        frame_sel;

  // table updates
  tlbpt_pkg::map_fill_t                 tlb_fill;
  tlbpt_pkg::map_fill_t                 pt_fill;

  // frames are never freed: the next free frame just counts up and saturates
  logic [tlbpt_pkg::NFF_W-1:0]          next_free_frame;

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;
  assign req_fire  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_page   <= virt_addr[tlbpt_pkg::VA_W-1:tlbpt_pkg::OFFSET_W];
      s1_offset <= virt_addr[tlbpt_pkg::OFFSET_W-1:0];
    end
  end

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk       (clk),
    .rst       (rst),
    .look_page (s1_page),
    .fill      (tlb_fill),
    .lookup    (tlb_res)
  );

  // the frame memory is read as the beat enters the input register
  tlbpt_page_table u_page_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (req_fire),
    .rd_page   (virt_addr[tlbpt_pkg::VA_W-1:tlbpt_pkg::OFFSET_W]),
    .look_page (s1_page),
    .fill      (pt_fill),
    .present   (pt_present),
    .rd_frame  (pt_frame)
  );

  // hit: tlb frame; miss but present: page table frame; fault: new frame
  assign fault = !tlb_res.hit && !pt_present;

  always_comb begin
    if (tlb_res.hit) begin
      frame_sel = tlb_res.frame;
    end else if (pt_present) begin
      frame_sel = pt_frame;
    end else begin
      frame_sel = next_free_frame[tlbpt_pkg::FRAME_W-1:0];
    end
  end

  // every miss refills the tlb at the fifo pointer
  always_comb begin
    tlb_fill.en    = s1_adv && !tlb_res.hit;
    tlb_fill.page  = s1_page;
    tlb_fill.frame = frame_sel;
    pt_fill.en     = s1_adv && fault;
    pt_fill.page   = s1_page;
    pt_fill.frame  = frame_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free_frame <= '0;
    end else if (pt_fill.en &&
                 next_free_frame < tlbpt_pkg::NFF_W'(tlbpt_pkg::PAGE_COUNT)) begin
      next_free_frame <= next_free_frame + 1'b1;
    end
  end

  // response register; the statistics counters double as its count fields
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      phys_addr  <= {frame_sel, s1_offset};
      tlb_hit    <= tlb_res.hit;
      page_fault <= fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_so_far     <= '0;
      faults_so_far   <= '0;
      accesses_so_far <= '0;
    end else if (s1_adv) begin
      accesses_so_far <= accesses_so_far + 1'b1;
      if (tlb_res.hit) begin
        hits_so_far <= hits_so_far + 1'b1;
      end
      if (fault) begin
        faults_so_far <= faults_so_far + 1'b1;
      end
    end
  end

  // a beat is either a tlb hit or a page fault or neither, never both
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(tlb_hit && page_fault))
    else $error("tlb hit and page fault flagged together");

  // each beat leaving the input register bumps the access count by one
  assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> accesses_so_far == $past(accesses_so_far) + 32'd1)
    else $error("access count out of step with translated beats");

  // the free frame counter never runs past the number of frames
  assert property (@(posedge clk) disable iff (rst)
    next_free_frame <= tlbpt_pkg::NFF_W'(tlbpt_pkg::PAGE_COUNT))
    else $error("free frame counter beyond frame count");

  // nothing is presented right after reset
  assert property (@(posedge clk)
    rst |=> !rsp_valid && !s1_valid)
    else $error("beat present after reset");

endmodule
`default_nettype wire
